>>> rtl/pixel_readout_word_decoder_defines.svh
// ----------------------------------------------------------------------------
// Pixel readout word decoder: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PIXEL_READOUT_WORD_DECODER_DEFINES_SVH
`define PIXEL_READOUT_WORD_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define PRWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PRWD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRWD_ASSERT(lbl, prop, msg)
`define PRWD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/prwd_pkg.sv
// ----------------------------------------------------------------------------
// Pixel readout word decoder package
// Word kinds, special chip codes, the timeout group table and the result type.
// ----------------------------------------------------------------------------
package prwd_pkg;

	localparam logic [3:0] KIND_BEGIN    = 4'd0;
	localparam logic [3:0] KIND_END      = 4'd1;
	localparam logic [3:0] KIND_GAP      = 4'd2;
	localparam logic [3:0] KIND_DUMMY    = 4'd3;
	localparam logic [3:0] KIND_HIT      = 4'd4;
	localparam logic [3:0] KIND_BAD_CHAN = 4'd5;
	localparam logic [3:0] KIND_TIMEOUT  = 4'd6;
	localparam logic [3:0] KIND_EVNUM    = 4'd7;
	localparam logic [3:0] KIND_TRAILER  = 4'd8;
	localparam logic [3:0] KIND_FIFO_NF  = 4'd9;

	localparam logic [4:0] CHIP_LAST_ROC = 5'd25;
	localparam logic [4:0] CHIP_GAP      = 5'd26;
	localparam logic [4:0] CHIP_DUMMY    = 5'd27;
	localparam logic [4:0] CHIP_FIFO_NF  = 5'd28;
	localparam logic [4:0] CHIP_TIMEOUT  = 5'd29;
	localparam logic [4:0] CHIP_TRAILER  = 5'd30;

	localparam logic [6:0] ROW_TOP       = 7'd80;
	localparam logic [7:0] PIX_LIMIT     = 8'd160;

	typedef struct packed {
		logic [3:0]  kind;
		logic [5:0]  channel;
		logic [4:0]  chip_id;
		logic [5:0]  column;
		logic [6:0]  row;
		logic [7:0]  low_byte;
		logic [4:0]  sub_mask;
		logic [5:0]  channel_base;
		logic [1:0]  fsm_status;
		logic [3:0]  error_flags;
		logic [7:0]  error_event;
		logic [23:0] event_out;
	} res_t;

	function automatic logic [4:0] group_offset(input logic [2:0] grp);
		logic [4:0] off;
		begin
			case (grp)
				3'd0: off = 5'd0;
				3'd1: off = 5'd4;
				3'd2: off = 5'd9;
				3'd3: off = 5'd13;
				3'd4: off = 5'd18;
				3'd5: off = 5'd22;
				3'd6: off = 5'd27;
				default: off = 5'd31;
			endcase
			return off;
		end
	endfunction

endpackage

>>> rtl/pixel_readout_word_decoder.sv
// ----------------------------------------------------------------------------
// Pixel readout word decoder
// Registers each readout word, classifies it and holds the decoded result.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  word      in         word_valid / word_stall     word_in, event_number
//  result    out        result_valid / result_stall kind .. event_out
//
//  An accepted item passes through the input register into the result register.
//  One item is accepted per cycle while the result side is not stalled.
//  A stalled result holds; the input register still takes one further item.
//  Reset clears the valid flags of both registers.
module pixel_readout_word_decoder #(
	parameter int MAX_CHANNEL = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [31:0] word_in,
	input  logic [23:0] event_number,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  kind,
	output logic [5:0]  channel,
	output logic [4:0]  chip_id,
	output logic [5:0]  column,
	output logic [6:0]  row,
	output logic [7:0]  low_byte,
	output logic [4:0]  sub_mask,
	output logic [5:0]  channel_base,
	output logic [1:0]  fsm_status,
	output logic [3:0]  error_flags,
	output logic [7:0]  error_event,
	output logic [23:0] event_out
);
	import prwd_pkg::*;

	`include "pixel_readout_word_decoder_defines.svh"

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [23:0] event_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res_next;
	logic        load_s2;
	logic        load_s1;

	assign load_s2    = !valid_s2 || !result_stall;
	assign load_s1    = !valid_s1 || load_s2;
	assign word_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && word_valid) begin
			word_s1  <= word_in;
			event_s1 <= event_number;
		end
	end

	prwd_decode #(
		.MAX_CHANNEL(MAX_CHANNEL)
	) u_decode (
		.word_in      (word_s1),
		.event_number (event_s1),
		.res          (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign kind         = res_s2.kind;
	assign channel      = res_s2.channel;
	assign chip_id      = res_s2.chip_id;
	assign column       = res_s2.column;
	assign row          = res_s2.row;
	assign low_byte     = res_s2.low_byte;
	assign sub_mask     = res_s2.sub_mask;
	assign channel_base = res_s2.channel_base;
	assign fsm_status   = res_s2.fsm_status;
	assign error_flags  = res_s2.error_flags;
	assign error_event  = res_s2.error_event;
	assign event_out    = res_s2.event_out;

	`PRWD_ASSERT_RST(a_reset_empty, !arst_n |-> !valid_s2, "result valid during reset")
	`PRWD_ASSERT(a_advance, valid_s1 && !valid_s2 |=> valid_s2, "item lost between registers")
	`PRWD_ASSERT(a_kind_range, valid_s2 |-> kind <= KIND_FIFO_NF, "kind out of range")
	`PRWD_ASSERT(a_hit_channel, valid_s2 && kind == KIND_HIT |-> channel != 6'd0 && channel <= 6'(MAX_CHANNEL), "hit on a channel out of range")
	`PRWD_ASSERT(a_pixel_only_hit, valid_s2 && kind != KIND_HIT |-> column == 6'd0 && row == 7'd0, "pixel address on a non-hit item")

endmodule

>>> rtl/prwd_decode.sv
// ----------------------------------------------------------------------------
// Word classifier
// Sorts one readout word into its kind and extracts the fields for that kind.
// ----------------------------------------------------------------------------
module prwd_decode #(
	parameter int MAX_CHANNEL = 36
) (
	input  logic [31:0]    word_in,
	input  logic [23:0]    event_number,
	output prwd_pkg::res_t res
);
	import prwd_pkg::*;

	logic [5:0] chan;
	logic [4:0] chip;
	logic [7:0] pix;

	assign chan = word_in[31:26];
	assign chip = word_in[25:21];
	assign pix  = word_in[15:8];

	always_comb begin
		res              = '0;
		res.channel      = chan;
		res.chip_id      = chip;
		res.event_out    = event_number;
		if (word_in[27:0] == 28'd0) begin
			res.kind = KIND_BEGIN;
		end else if (chip > CHIP_LAST_ROC) begin
			if (&word_in) begin
				res.kind = KIND_END;
			end else begin
				unique case (chip)
					CHIP_GAP: begin
						res.kind     = KIND_GAP;
						res.low_byte = word_in[7:0];
					end
					CHIP_DUMMY: begin
						res.kind     = KIND_DUMMY;
						res.low_byte = word_in[7:0];
					end
					CHIP_TIMEOUT: begin
						res.kind         = KIND_TIMEOUT;
						res.error_event  = word_in[20:13];
						res.sub_mask     = word_in[4:0];
						res.channel_base = {1'b0, group_offset(word_in[10:8])} + 6'd1;
					end
					CHIP_TRAILER: begin
						res.kind        = KIND_TRAILER;
						res.error_event = word_in[20:13];
						res.low_byte    = word_in[7:0];
						res.fsm_status  = word_in[10:9];
						res.error_flags = {2'b00, word_in[8], word_in[11]};
					end
					CHIP_FIFO_NF: begin
						res.kind        = KIND_FIFO_NF;
						res.error_event = word_in[20:13];
						res.sub_mask    = word_in[4:0];
						res.error_flags = {word_in[7], word_in[6], 2'b00};
					end
					default: begin
						res.kind        = KIND_EVNUM;
						res.error_event = word_in[20:13];
						res.low_byte    = word_in[7:0];
					end
				endcase
			end
		end else if (chan != 6'd0 && chan <= 6'(MAX_CHANNEL)) begin
			res.kind     = KIND_HIT;
			res.column   = {word_in[20:16], pix[0]};
			res.row      = (pix < PIX_LIMIT) ? (ROW_TOP - pix[7:1]) : 7'd0;
			res.low_byte = word_in[7:0];
		end else begin
			res.kind = KIND_BAD_CHAN;
		end
	end

endmodule

>>> bench/pixel_readout_word_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel readout word decoder testbench
// Streams directed and random readout words through the decoder with random
// gaps on the word side and random stalls on the result side. Each accepted
// word is decoded independently here and every result is compared field by
// field, in order, against that prediction.
// ----------------------------------------------------------------------------
module pixel_readout_word_decoder_tb;
	import prwd_pkg::*;

	localparam int MAX_CH = 36;
	localparam int CYCLE_LIMIT = 250000;
	localparam logic [4:0] CHIP_EVNUM = 5'd31;
	localparam logic [47:0] GROUP_START = {6'd31, 6'd27, 6'd22, 6'd18, 6'd13, 6'd9, 6'd4, 6'd0};

	typedef struct {
		logic [31:0] word;
		logic [23:0] ev;
		bit          drain;
	} word_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        word_valid = 1'b0;
	logic        word_stall;
	logic [31:0] word_in = '0;
	logic [23:0] event_number = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [3:0]  kind;
	logic [5:0]  channel;
	logic [4:0]  chip_id;
	logic [5:0]  column;
	logic [6:0]  row;
	logic [7:0]  low_byte;
	logic [4:0]  sub_mask;
	logic [5:0]  channel_base;
	logic [1:0]  fsm_status;
	logic [3:0]  error_flags;
	logic [7:0]  error_event;
	logic [23:0] event_out;

	word_item_t pending_words[$];
	res_t       decoded_words[$];
	res_t       want;
	int         errors = 0;
	int         cycles = 0;
	int         gap_left = 0;
	int         calm_words = 0;
	int         stall_left = 0;
	int         calm_results = 0;

	pixel_readout_word_decoder #(
		.MAX_CHANNEL(MAX_CH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.word_in(word_in),
		.event_number(event_number),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.channel(channel),
		.chip_id(chip_id),
		.column(column),
		.row(row),
		.low_byte(low_byte),
		.sub_mask(sub_mask),
		.channel_base(channel_base),
		.fsm_status(fsm_status),
		.error_flags(error_flags),
		.error_event(error_event),
		.event_out(event_out)
	);

	function automatic res_t decode_word(input logic [31:0] w, input logic [23:0] ev);
		res_t       r;
		logic [4:0] chip;
		logic [7:0] pix;
		r = '0;
		chip = w[25:21];
		pix = w[15:8];
		r.channel = w[31:26];
		r.chip_id = chip;
		r.event_out = ev;
		if (w[27:0] == 28'd0) begin
			r.kind = KIND_BEGIN;
		end else if (chip > CHIP_LAST_ROC) begin
			if (&w) begin
				r.kind = KIND_END;
			end else if (chip == CHIP_GAP || chip == CHIP_DUMMY) begin
				r.kind = (chip == CHIP_GAP) ? KIND_GAP : KIND_DUMMY;
				r.low_byte = w[7:0];
			end else begin
				r.error_event = w[20:13];
				case (chip)
					CHIP_TIMEOUT: begin
						r.kind = KIND_TIMEOUT;
						r.sub_mask = w[4:0];
						r.channel_base = GROUP_START[6 * w[10:8] +: 6] + 6'd1;
					end
					CHIP_EVNUM: begin
						r.kind = KIND_EVNUM;
						r.low_byte = w[7:0];
					end
					CHIP_TRAILER: begin
						r.kind = KIND_TRAILER;
						r.low_byte = w[7:0];
						r.fsm_status = w[10:9];
						r.error_flags = {2'b00, w[8], w[11]};
					end
					default: begin
						r.kind = KIND_FIFO_NF;
						r.sub_mask = w[4:0];
						r.error_flags = {w[7], w[6], 2'b00};
					end
				endcase
			end
		end else if (w[31:26] != 6'd0 && int'(w[31:26]) <= MAX_CH) begin
			r.kind = KIND_HIT;
			r.column = {w[20:16], pix[0]};
			r.row = (pix < 8'd160) ? 7'd80 - pix[7:1] : 7'd0;
			r.low_byte = w[7:0];
		end else begin
			r.kind = KIND_BAD_CHAN;
		end
		return r;
	endfunction

	function automatic logic [31:0] pack_word(input int chan, input int chip, input logic [20:0] body);
		return {6'(chan), 5'(chip), body};
	endfunction

	function automatic void queue_word(input logic [31:0] w, input logic [23:0] ev, input bit drain);
		word_item_t it;
		it.word = w;
		it.ev = ev;
		it.drain = drain;
		pending_words.push_back(it);
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL pixel_readout_word_decoder");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
			word_in <= '0;
			event_number <= '0;
			gap_left = 0;
		end else begin
			if (word_valid && !word_stall) begin
				decoded_words.push_back(decode_word(word_in, event_number));
				void'(pending_words.pop_front());
				if (calm_words > 0) begin
					calm_words--;
					gap_left = 0;
				end else if ($urandom_range(0, 49) == 0) begin
					calm_words = $urandom_range(20, 80);
					gap_left = 0;
				end else if ($urandom_range(0, 19) == 0) begin
					gap_left = $urandom_range(10, 40);
				end else if ($urandom_range(0, 2) == 0) begin
					gap_left = $urandom_range(1, 3);
				end else begin
					gap_left = 0;
				end
			end
			if (word_valid && word_stall) begin
				word_valid <= 1'b1;
			end else if (gap_left > 0 || pending_words.size() == 0 ||
					(pending_words[0].drain && decoded_words.size() != 0)) begin
				word_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				word_valid <= 1'b1;
				word_in <= pending_words[0].word;
				event_number <= pending_words[0].ev;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (decoded_words.size() == 0) begin
					$error("result with no item outstanding: kind 0x%0h channel 0x%0h", kind, channel);
					errors++;
				end else begin
					want = decoded_words.pop_front();
					check_field("kind", want.kind, kind);
					check_field("channel", want.channel, channel);
					check_field("chip_id", want.chip_id, chip_id);
					check_field("column", want.column, column);
					check_field("row", want.row, row);
					check_field("low_byte", want.low_byte, low_byte);
					check_field("sub_mask", want.sub_mask, sub_mask);
					check_field("channel_base", want.channel_base, channel_base);
					check_field("fsm_status", want.fsm_status, fsm_status);
					check_field("error_flags", want.error_flags, error_flags);
					check_field("error_event", want.error_event, error_event);
					check_field("event_out", want.event_out, event_out);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (calm_results > 0) begin
					calm_results--;
				end else if ($urandom_range(0, 99) == 0) begin
					calm_results = $urandom_range(50, 200);
				end else if ($urandom_range(0, 29) == 0) begin
					stall_left = $urandom_range(10, 40);
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	initial begin
		int          i;
		int          sel;
		logic [31:0] w;
		logic [23:0] ev;

		arst_n <= 1'b0;

		queue_word(32'h0000_0000, 24'h000000, 1'b0);
		queue_word(32'hF000_0000, 24'hFFFFFF, 1'b0);
		queue_word(32'hFFFF_FFFF, 24'h123456, 1'b0);
		queue_word(32'hFFFF_FFFE, 24'h000001, 1'b0);
		queue_word(pack_word(5, 26, 21'h1F_FFFF), 24'hABCDEF, 1'b0);
		queue_word(pack_word(0, 27, 21'h00_00A5), 24'h000000, 1'b0);
		queue_word(pack_word(63, 28, 21'h1F_E0DF), 24'hFFFFFF, 1'b0);
		queue_word(pack_word(1, 28, 21'h00_0040), 24'h00FF00, 1'b0);
		queue_word(pack_word(2, 29, 21'h1F_E01F), 24'h000010, 1'b0);
		queue_word(pack_word(3, 29, 21'h00_0711), 24'h000011, 1'b0);
		queue_word(pack_word(4, 29, 21'h00_0300), 24'h000012, 1'b0);
		queue_word(pack_word(7, 30, 21'h1F_EFFF), 24'h000020, 1'b0);
		queue_word(pack_word(8, 30, 21'h00_0900), 24'h000021, 1'b0);
		queue_word(pack_word(9, 31, 21'h1F_E05A), 24'h000030, 1'b0);
		queue_word(pack_word(1, 0, 21'h00_0000), 24'h000040, 1'b0);
		queue_word(pack_word(MAX_CH, 25, 21'h1F_9FFF), 24'h000041, 1'b0);
		queue_word(pack_word(12, 3, 21'h0A_A07F), 24'h000042, 1'b0);
		queue_word(pack_word(20, 10, 21'h15_A001), 24'h000043, 1'b0);
		queue_word(pack_word(30, 17, 21'h1F_FF80), 24'h000044, 1'b0);
		queue_word(pack_word(0, 5, 21'h01_2345), 24'h000050, 1'b0);
		queue_word(pack_word(MAX_CH + 1, 0, 21'h00_0101), 24'h000051, 1'b0);
		queue_word(pack_word(63, 25, 21'h1F_FFFF), 24'h000052, 1'b0);
		queue_word(pack_word(6, 26, 21'h00_0000), 24'h000053, 1'b0);

		for (i = 0; i < 800; i++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				ev = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
			else
				ev = 24'($urandom());
			if (sel < 8)
				w = $urandom() & 32'hF000_0000;
			else if (sel < 11)
				w = 32'hFFFF_FFFF;
			else if (sel < 41)
				w = pack_word($urandom_range(0, 63), $urandom_range(26, 31), 21'($urandom()));
			else if (sel < 86)
				w = pack_word($urandom_range(1, MAX_CH), $urandom_range(0, 25), 21'($urandom()));
			else
				w = $urandom();
			queue_word(w, ev, (i == 400) || ($urandom_range(0, 199) == 0));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || decoded_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS pixel_readout_word_decoder");
		else
			$display("FAIL pixel_readout_word_decoder");
		$finish;
	end

endmodule
